FILE: rtl/b64nc_pkg.sv
// Shared types, codes and character tables for the streaming base64 codec.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package b64nc_pkg;

  // Register indexes of the configuration port.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_MODE      = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_OUT_LIMIT = 1'd1;

  // Widths fixed by the interface.
  localparam int unsigned CntW  = 13;
  localparam int unsigned CfgW  = 13;
  localparam logic [CntW-1:0] LIMIT_RESET = 13'd4096;

  // Operating modes.
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Status codes carried on the final result of a stream.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
  localparam logic [1:0] STATUS_NO_ROOM  = 2'd2;

  // Characters with a special meaning in the text.
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_UNDER   = 8'h5F;

  localparam logic [5:0] SEXTET_62 = 6'd62;
  localparam logic [5:0] SEXTET_63 = 6'd63;

  // One work unit handed from the front to the back: up to three produced
  // bytes, the count before the first of them, and the end-of-stream marks.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      n_data;
    logic            last;
    logic [1:0]      status;
    logic [CntW-1:0] base;
  } b64nc_job_t;

  // Sextet to alphabet character.
  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)           return w + 8'd65;
    else if (v < 6'd52)      return w + 8'd71;
    else if (v < SEXTET_62)  return w - 8'd4;
    else if (v == SEXTET_62) return CHAR_PLUS;
    else                     return CHAR_COMMA;
  endfunction

  // Character to sextet; bit 6 set when the character is accepted.
  function automatic logic [6:0] char_to_sextet(input logic [7:0] ch);
    logic [7:0] w;
    w = 8'd0;
    if (ch >= 8'h41 && ch <= 8'h5A)      w = ch - 8'd65;
    else if (ch >= 8'h61 && ch <= 8'h7A) w = ch - 8'd71;
    else if (ch >= 8'h30 && ch <= 8'h39) w = ch + 8'd4;
    else if (ch == CHAR_PLUS || ch == CHAR_MINUS) w = {2'b00, SEXTET_62};
    else if (ch == CHAR_COMMA || ch == CHAR_SLASH || ch == CHAR_UNDER)
      w = {2'b00, SEXTET_63};
    else if (ch == CHAR_PAD) w = 8'd0;
    else return 7'd0;
    return {1'b1, w[5:0]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/b64nc_front.sv
// Front end of the codec: configuration registers, stream state and the
// per-request work of encoding or decoding. Uses b64nc_pkg; feeds b64nc_queue.
`default_nettype none

module b64nc_front #(
  parameter int unsigned MAX_OUT = 4096
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [b64nc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [b64nc_pkg::CfgW-1:0]   cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [7:0]                   in_byte_i,
  input  wire logic                         in_last_i,
  input  wire logic                         q_full_i,
  output logic                              push_o,
  output b64nc_pkg::b64nc_job_t             job_o
);

  logic                          mode_q;
  logic [b64nc_pkg::CntW-1:0]    limit_q;
  logic [1:0]                    gp_q, gp_d;
  logic [17:0]                   held_q, held_d;
  logic [2:0]                    pad_q, pad_d;
  logic [b64nc_pkg::CntW-1:0]    prod_q, prod_d;
  logic                          stop_q, stop_d;
  logic [1:0]                    err_q, err_d;

  logic                          accept;
  logic [b64nc_pkg::CntW-1:0]    lim;
  logic [1:0]                    enc_pos;
  logic [5:0]                    sx0, sx1;
  logic [6:0]                    dec;
  logic [2:0]                    pad_n;
  logic [17:0]                   held_n;
  logic [5:0]                    sx_d;
  logic [2:0]                    newpos;
  logic                          c_pad, d_pad;
  logic [2:0][7:0]               cand;
  logic [1:0]                    try_cnt;
  logic                          may_stop;
  logic                          run;
  logic [1:0]                    n_out;
  logic [b64nc_pkg::CntW-1:0]    cnt;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign lim = ({19'd0, limit_q} > 32'(MAX_OUT)) ? 13'(MAX_OUT) : limit_q;
  assign dec = b64nc_pkg::char_to_sextet(in_byte_i);

  always_comb begin
    gp_d = gp_q;  held_d = held_q;  pad_d = pad_q;
    prod_d = prod_q;  stop_d = stop_q;  err_d = err_q;
    enc_pos = 2'd0;  sx0 = 6'd0;  sx1 = 6'd0;
    pad_n = pad_q;  held_n = held_q;  sx_d = 6'd0;  newpos = 3'd0;
    c_pad = 1'b0;  d_pad = 1'b0;
    cand = '0;  try_cnt = 2'd0;  may_stop = 1'b0;
    run = 1'b1;  n_out = 2'd0;  cnt = prod_q;

    if (err_q == b64nc_pkg::STATUS_OK && !stop_q) begin
      if (mode_q == b64nc_pkg::MODE_ENCODE) begin
        // A position of three left behind by the decoder starts a fresh group.
        enc_pos = (gp_q == 2'd3) ? 2'd0 : gp_q;
        case (enc_pos)
          2'd0: begin
            sx0 = in_byte_i[7:2];
            sx1 = {in_byte_i[1:0], 4'b0000};
            held_d = {16'd0, in_byte_i[1:0]};
            gp_d = 2'd1;
            try_cnt = in_last_i ? 2'd2 : 2'd1;
          end
          2'd1: begin
            sx0 = {held_q[1:0], in_byte_i[7:4]};
            sx1 = {in_byte_i[3:0], 2'b00};
            held_d = {14'd0, in_byte_i[3:0]};
            gp_d = 2'd2;
            try_cnt = in_last_i ? 2'd2 : 2'd1;
          end
          default: begin
            sx0 = {held_q[3:0], in_byte_i[7:6]};
            sx1 = in_byte_i[5:0];
            held_d = '0;
            gp_d = 2'd0;
            try_cnt = 2'd2;
          end
        endcase
        cand[0] = b64nc_pkg::sextet_to_char(sx0);
        cand[1] = b64nc_pkg::sextet_to_char(sx1);
      end else if (!(gp_q == 2'd0 && in_byte_i == b64nc_pkg::CHAR_NEWLINE)) begin
        if (!dec[6]) begin
          err_d = b64nc_pkg::STATUS_BAD_CHAR;
        end else begin
          if (gp_q != 2'd0 && in_byte_i == b64nc_pkg::CHAR_PAD) begin
            pad_n = pad_q | (3'b001 << (gp_q - 2'd1));
          end
          case (gp_q)
            2'd0:    held_n[17:12] = held_q[17:12] | dec[5:0];
            2'd1:    held_n[11:6]  = held_q[11:6]  | dec[5:0];
            2'd2:    held_n[5:0]   = held_q[5:0]   | dec[5:0];
            default: sx_d = dec[5:0];
          endcase
          newpos = {1'b0, gp_q} + 3'd1;
          if (!newpos[2] && !in_last_i) begin
            gp_d = newpos[1:0];
            held_d = held_n;
            pad_d = pad_n;
          end else begin
            // Group complete, or cut short by the end of the stream.
            c_pad = (newpos < 3'd3) || pad_n[1];
            d_pad = !newpos[2] || pad_n[2];
            gp_d = 2'd0;  held_d = '0;  pad_d = '0;
            cand[0] = {held_n[17:12], held_n[11:10]};
            cand[1] = {held_n[9:6], held_n[5:2]};
            cand[2] = {held_n[1:0], sx_d};
            try_cnt = c_pad ? 2'd1 : (d_pad ? 2'd2 : 2'd3);
            may_stop = c_pad || d_pad;
          end
        end
      end

      for (int k = 0; k < 3; k++) begin
        if (2'(k) < try_cnt && run) begin
          if (cnt >= lim) begin
            err_d = b64nc_pkg::STATUS_NO_ROOM;
            run = 1'b0;
          end else begin
            cnt = cnt + 13'd1;
            n_out = n_out + 2'd1;
          end
        end
      end
      prod_d = cnt;
      if (run && may_stop) stop_d = 1'b1;
    end

    job_o.data   = cand;
    job_o.n_data = n_out;
    job_o.last   = in_last_i;
    job_o.status = err_d;
    job_o.base   = prod_q;
    push_o = accept && (n_out != 2'd0 || in_last_i);

    if (in_last_i) begin
      gp_d = 2'd0;  held_d = '0;  pad_d = '0;
      prod_d = '0;  stop_d = 1'b0;  err_d = b64nc_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= b64nc_pkg::MODE_ENCODE;
      limit_q <= b64nc_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        b64nc_pkg::CFG_MODE:      mode_q  <= cfg_data_i[0];
        b64nc_pkg::CFG_OUT_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q   <= 2'd0;
      held_q <= '0;
      pad_q  <= '0;
      prod_q <= '0;
      stop_q <= 1'b0;
      err_q  <= b64nc_pkg::STATUS_OK;
    end else if (accept) begin
      gp_q   <= gp_d;
      held_q <= held_d;
      pad_q  <= pad_d;
      prod_q <= prod_d;
      stop_q <= stop_d;
      err_q  <= err_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/b64nc_queue.sv
// Two-entry queue of work units between the front and the back of the codec.
// Uses the job type of b64nc_pkg.
`default_nettype none

module b64nc_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire b64nc_pkg::b64nc_job_t job_i,
  output logic                       full_o,
  input  wire logic                  pop_i,
  output logic                       head_valid_o,
  output b64nc_pkg::b64nc_job_t      head_o
);

  b64nc_pkg::b64nc_job_t slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = slot_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/b64nc_back.sv
// Back end of the codec: unpacks each work unit into single results and holds
// them in the output register. Uses b64nc_pkg; reads the head of b64nc_queue.
`default_nettype none

module b64nc_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       head_valid_i,
  input  wire b64nc_pkg::b64nc_job_t      head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [7:0]                      out_byte_o,
  output logic                            has_data_o,
  output logic                            out_last_o,
  output logic [1:0]                      status_o,
  output logic [b64nc_pkg::CntW-1:0]      out_total_o
);

  logic [1:0]                 idx_q, idx_d;
  logic                       valid_q, valid_d;
  logic [7:0]                 byte_q;
  logic                       has_q, last_q;
  logic [1:0]                 status_q;
  logic [b64nc_pkg::CntW-1:0] total_q;

  logic [1:0] res_cnt;
  logic       at_end, load, has;

  assign res_cnt = (head_i.n_data == 2'd0) ? 2'd1 : head_i.n_data;
  assign at_end  = (idx_q == res_cnt - 2'd1);
  assign load    = head_valid_i && (!valid_q || !out_stall_i);
  assign has     = (head_i.n_data != 2'd0);
  assign pop_o   = load && at_end;

  always_comb begin
    idx_d = idx_q;
    if (load) idx_d = at_end ? 2'd0 : idx_q + 2'd1;
    valid_d = load ? 1'b1 : (valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= has ? head_i.data[idx_q] : 8'd0;
      has_q    <= has;
      last_q   <= head_i.last && at_end;
      status_q <= (head_i.last && at_end) ? head_i.status : b64nc_pkg::STATUS_OK;
      total_q  <= has ? head_i.base + 13'(idx_q) + 13'd1 : head_i.base;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign has_data_o  = has_q;
  assign out_last_o  = last_q;
  assign status_o    = status_q;
  assign out_total_o = total_q;

endmodule

`default_nettype wire

FILE: rtl/base64_name_codec.sv
// Top level of the streaming base64 codec with unpadded output.
// Depends on b64nc_pkg, b64nc_front, b64nc_queue and b64nc_back.
//
// One byte enters per request. In encode mode (register 0 = 0) raw bytes
// become characters of the alphabet A-Z a-z 0-9 '+' ',' with no padding; in
// decode mode (register 0 = 1) text is taken in groups of four, with '-', '/'
// and '_' accepted as well and '=' read as zero. A pad in the third or fourth
// place of a group ends decoding; a bad character, or a byte beyond the
// output limit (register 1, capped at MAX_OUT), latches an error. After a stop
// or an error the input is swallowed until the request marked last, whose
// final result carries the status and the stream's total byte count. The
// front end takes one request per clock whenever its two-entry work queue has
// room, and does the whole encode or decode step for it in that cycle. The
// back end delivers one result per clock while the output is not stalled,
// from a registered output stage, so a request that yields k results (one to
// three) holds the back end until all k are delivered, and a decode character
// that only fills a group yields nothing and is never queued. Sustained
// throughput is therefore set by the back end's one-result-per-cycle port.
// There is no clearing pass; the block is ready straight after reset.
`default_nettype none

module base64_name_codec #(
  parameter int unsigned MAX_OUT = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [b64nc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [b64nc_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    in_byte_i,
  input  wire logic                          in_last_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [7:0]                         out_byte_o,
  output logic                               has_data_o,
  output logic                               out_last_o,
  output logic [1:0]                         status_o,
  output logic [b64nc_pkg::CntW-1:0]         out_total_o
);

  // Work units travel from the front to the back through the queue.
  b64nc_pkg::b64nc_job_t push_job;
  b64nc_pkg::b64nc_job_t head_job;
  logic                  push;
  logic                  q_full;
  logic                  head_valid;
  logic                  pop;

  b64nc_front #(
    .MAX_OUT (MAX_OUT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  b64nc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (push_job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_job)
  );

  b64nc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .has_data_o   (has_data_o),
    .out_last_o   (out_last_o),
    .status_o     (status_o),
    .out_total_o  (out_total_o)
  );

  // The front never hands a unit to a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_full)
    else $error("work unit pushed into a full queue");

  // Only the final result of a stream may report a non-zero status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_last_o |-> status_o == b64nc_pkg::STATUS_OK)
    else $error("status reported before the end of the stream");

  // A result without data is only ever the final result, and carries zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_data_o |-> out_last_o && out_byte_o == 8'd0)
    else $error("empty result that is not the final one");

  // A produced byte always counts towards the total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_data_o |-> out_total_o != '0)
    else $error("produced byte with a zero running total");

endmodule

`default_nettype wire

FILE: bench/base64_name_codec_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the streaming base64 codec: byte and text streams
// are checked result by result against an in-bench prediction of the codec.
// Depends on b64nc_pkg and base64_name_codec from the rtl folder.

module base64_name_codec_tb;

  localparam int unsigned CNT_W     = b64nc_pkg::CntW;
  localparam int unsigned CFG_W     = b64nc_pkg::CfgW;
  localparam int unsigned CFG_IDX_W = b64nc_pkg::CfgIdxW;

  localparam int unsigned CODEC_MAX_OUT = 4096;
  localparam int RANDOM_ITEMS = 130;  // random requests to queue after the directed part
  localparam int DRAIN_CYCLES = 8;    // settle time once the last result is back
  localparam int HOLD_AFTER   = 70;   // accepted requests before the long output hold
  localparam int HOLD_CYCLES  = 60;

  // One input request and one result, at the widths of the ports.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } codec_request_t;

  typedef struct packed {
    logic [7:0]       data;
    logic             has_data;
    logic             last;
    logic [1:0]       status;
    logic [CNT_W-1:0] total;
  } codec_result_t;

  // Every input of the block starts at a known value.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic [7:0]           in_byte_i   = 8'd0;
  logic                 in_last_i   = 1'b0;
  logic                 out_stall_i = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [7:0]           out_byte_o;
  logic                 has_data_o;
  logic                 out_last_o;
  logic [1:0]           status_o;
  logic [CNT_W-1:0]     out_total_o;

  base64_name_codec #(
    .MAX_OUT(CODEC_MAX_OUT)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .has_data_o (has_data_o),
    .out_last_o (out_last_o),
    .status_o   (status_o),
    .out_total_o(out_total_o)
  );

  // Requests waiting to be driven, and the results the codec owes us, oldest first.
  codec_request_t pending_bytes[$];
  codec_result_t  expected_outputs[$];
  codec_result_t  step_outputs[$];
  codec_result_t  oldest_output;

  // The bench's own copy of the codec's registers and stream state.
  logic             cur_mode;
  logic [CNT_W-1:0] cur_limit;
  logic [1:0]       grp_pos;
  logic [17:0]      held_bits;
  logic [2:0]       pad_marks;
  logic [CNT_W-1:0] produced_cnt;
  logic             stopped;
  logic [1:0]       err_code;

  string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+,";

  int send_idle_pct = 28;
  int recv_idle_pct = 70;
  int accepted_count;
  int queued_count;
  int mismatch_count;
  int hold_left;
  bit hold_done;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction. Each accepted request is run through this model of the codec
  // and the results it must cause are appended to expected_outputs.
  // ---------------------------------------------------------------------------

  function automatic void clear_stream_state();
    grp_pos      = 2'd0;
    held_bits    = 18'd0;
    pad_marks    = 3'd0;
    produced_cnt = '0;
    stopped      = 1'b0;
    err_code     = b64nc_pkg::STATUS_OK;
  endfunction

  // Emits one produced byte unless the stream has used up its room; the limit
  // register saturates at the block's MAX_OUT.
  function automatic bit emit_byte(input logic [7:0] b);
    logic [CNT_W-1:0] lim;
    lim = (cur_limit > CNT_W'(CODEC_MAX_OUT)) ? CNT_W'(CODEC_MAX_OUT) : cur_limit;
    if (produced_cnt >= lim) begin
      err_code = b64nc_pkg::STATUS_NO_ROOM;
      return 1'b0;
    end
    produced_cnt = produced_cnt + 1'b1;
    step_outputs.insert(step_outputs.size(),
                        '{data: b, has_data: 1'b1, last: 1'b0,
                          status: b64nc_pkg::STATUS_OK, total: produced_cnt});
    return 1'b1;
  endfunction

  // Once one character of a request has been refused, the rest are dropped.
  function automatic bit emit_char(input bit ok, input logic [5:0] sextet);
    if (!ok) return 1'b0;
    return emit_byte(b64_alphabet[sextet]);
  endfunction

  function automatic int text_value(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return int'(ch - "A");
    if (ch >= "a" && ch <= "z") return int'(ch - "a") + 26;
    if (ch >= "0" && ch <= "9") return int'(ch - "0") + 52;
    if (ch == b64nc_pkg::CHAR_PLUS || ch == b64nc_pkg::CHAR_MINUS) return 62;
    if (ch == b64nc_pkg::CHAR_COMMA || ch == b64nc_pkg::CHAR_SLASH ||
        ch == b64nc_pkg::CHAR_UNDER) return 63;
    if (ch == b64nc_pkg::CHAR_PAD) return 0;
    return -1;
  endfunction

  // Encoding: a group position of three, left behind by the decoder, counts
  // as the start of a fresh group.
  function automatic void encode_byte(input logic [7:0] x, input logic last);
    bit ok;
    logic [1:0] pos;
    pos = (grp_pos > 2'd2) ? 2'd0 : grp_pos;
    case (pos)
      2'd0: begin
        ok        = emit_char(1'b1, x[7:2]);
        held_bits = {16'd0, x[1:0]};
        grp_pos   = 2'd1;
        if (last) ok = emit_char(ok, {held_bits[1:0], 4'd0});
      end
      2'd1: begin
        ok        = emit_char(1'b1, {held_bits[1:0], x[7:4]});
        held_bits = {14'd0, x[3:0]};
        grp_pos   = 2'd2;
        if (last) ok = emit_char(ok, {held_bits[3:0], 2'd0});
      end
      default: begin
        ok        = emit_char(1'b1, {held_bits[3:0], x[7:6]});
        ok        = emit_char(ok, x[5:0]);
        held_bits = 18'd0;
        grp_pos   = 2'd0;
      end
    endcase
  endfunction

  // Decoding: characters gather into groups of four; a short group at the end
  // of the stream is completed with pads, and a pad in the third or fourth
  // place stops the stream after one or two bytes.
  function automatic void decode_char(input logic [7:0] x, input logic last);
    int pos;
    int v;
    logic [5:0] a, b, c, d;
    bit c_pad, d_pad;
    pos = grp_pos;
    d   = 6'd0;
    if (pos == 0 && x == b64nc_pkg::CHAR_NEWLINE) return;
    v = text_value(x);
    if (v < 0) begin
      err_code = b64nc_pkg::STATUS_BAD_CHAR;
      return;
    end
    if (pos >= 1 && x == b64nc_pkg::CHAR_PAD) pad_marks[pos-1] = 1'b1;
    if (pos < 3) held_bits = held_bits | (18'(v) << (12 - 6 * pos));
    else d = 6'(v);
    pos++;
    grp_pos = 2'(pos);
    if (pos < 4 && !last) return;

    a = held_bits[17:12];
    b = held_bits[11:6];
    c = held_bits[5:0];
    c_pad = (pos < 3) || pad_marks[1];
    d_pad = (pos < 4) || pad_marks[2];
    grp_pos   = 2'd0;
    held_bits = 18'd0;
    pad_marks = 3'd0;

    if (!emit_byte({a, b[5:4]})) return;
    if (c_pad) begin
      stopped = 1'b1;
      return;
    end
    if (!emit_byte({b[3:0], c[5:2]})) return;
    if (d_pad) begin
      stopped = 1'b1;
      return;
    end
    void'(emit_byte({c[1:0], d}));
  endfunction

  // The last request of a stream always yields a final result carrying the
  // status and the total; if it produced nothing, an empty one is made.
  function automatic void predict_codec_step(input logic [7:0] x, input logic last);
    codec_result_t tail;
    step_outputs.delete();
    if (err_code == b64nc_pkg::STATUS_OK && !stopped) begin
      if (cur_mode == b64nc_pkg::MODE_ENCODE) encode_byte(x, last);
      else decode_char(x, last);
    end
    if (last) begin
      if (step_outputs.size() == 0) step_outputs.insert(0, '0);
      tail        = step_outputs.pop_back();
      tail.last   = 1'b1;
      tail.status = err_code;
      tail.total  = produced_cnt;
      step_outputs.insert(step_outputs.size(), tail);
      clear_stream_state();
    end
    foreach (step_outputs[i]) expected_outputs.insert(expected_outputs.size(), step_outputs[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. A request stays on the port until it is taken; only then may the
  // next one be offered or the port fall idle. Prediction happens at the very
  // edge at which the codec accepts the request.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= 8'd0;
      in_last_i  <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_codec_step(in_byte_i, in_last_i);
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        // During the long output hold the sender never pauses, so the work
        // queue fills and the codec has to push back on its input.
        if (pending_bytes.size() != 0 &&
            (hold_left != 0 || $urandom_range(0, 99) >= send_idle_pct)) begin
          in_valid_i <= 1'b1;
          in_byte_i  <= pending_bytes[0].data;
          in_last_i  <= pending_bytes[0].last;
          void'(pending_bytes.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s, got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor and output back-pressure. Every result taken is compared field by
  // field with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_outputs.size() == 0) begin
          flag_mismatch("result with nothing pending, out_total", out_total_o, 0);
        end else begin
          oldest_output = expected_outputs.pop_front();
          if (out_byte_o !== oldest_output.data)
            flag_mismatch("out_byte", out_byte_o, oldest_output.data);
          if (has_data_o !== oldest_output.has_data)
            flag_mismatch("has_data", has_data_o, oldest_output.has_data);
          if (out_last_o !== oldest_output.last)
            flag_mismatch("out_last", out_last_o, oldest_output.last);
          if (status_o !== oldest_output.status)
            flag_mismatch("status", status_o, oldest_output.status);
          if (out_total_o !== oldest_output.total)
            flag_mismatch("out_total", out_total_o, oldest_output.total);
        end
      end

      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (!hold_done && accepted_count >= HOLD_AFTER && in_valid_i) begin
        hold_left   <= HOLD_CYCLES;
        hold_done   <= 1'b1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b, input logic last);
    pending_bytes.insert(pending_bytes.size(), '{data: b, last: last});
    queued_count++;
  endtask

  // Waits until every request has gone in and every result has come out, then
  // a little longer, as a text character that only fills a group yields
  // nothing that could be waited for.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || in_valid_i || expected_outputs.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    if (idx == b64nc_pkg::CFG_MODE) cur_mode = val[0];
    else if (idx == b64nc_pkg::CFG_OUT_LIMIT) cur_limit = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_text_char();
    case ($urandom_range(0, 19))
      0:       return b64nc_pkg::CHAR_MINUS;
      1:       return b64nc_pkg::CHAR_SLASH;
      2:       return b64nc_pkg::CHAR_UNDER;
      default: return b64_alphabet[$urandom_range(0, 63)];
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1, 2:    return CFG_W'($urandom_range(1, 12));
      3:       return b64nc_pkg::LIMIT_RESET;
      4:       return '1;
      default: return CFG_W'($urandom_range(0, 8191));
    endcase
  endfunction

  task automatic queue_raw_stream(input bit with_end);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 8);
    for (int i = 0; i < n; i++)
      queue_byte(8'($urandom_range(0, 255)), with_end && i == n - 1);
  endtask

  // Mostly well-formed text: whole groups of alphabet characters, now and then
  // a pad or two at the end of a group, a newline between groups, a short
  // final group, and occasionally a stray byte or a newline inside a group.
  task automatic queue_text_stream(input bit with_end);
    logic [7:0] txt[$];
    int n_groups;
    int cut;
    n_groups = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
    for (int g = 0; g < n_groups; g++) begin
      if ($urandom_range(0, 7) == 0) txt.insert(txt.size(), b64nc_pkg::CHAR_NEWLINE);
      repeat (4) txt.insert(txt.size(), pick_text_char());
      case ($urandom_range(0, 9))
        0: begin
          txt[$]   = b64nc_pkg::CHAR_PAD;
          txt[$-1] = b64nc_pkg::CHAR_PAD;
        end
        1:       txt[$] = b64nc_pkg::CHAR_PAD;
        default: ;
      endcase
      if ($urandom_range(0, 11) == 0)
        txt[$ - $urandom_range(0, 3)] = $urandom_range(0, 1) ? b64nc_pkg::CHAR_NEWLINE
                                                             : 8'($urandom_range(0, 255));
    end
    cut = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (cut) void'(txt.pop_back());
    foreach (txt[i]) queue_byte(txt[i], with_end && i == txt.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int random_start;
    bit open_end;
    logic [CFG_W-1:0] mode_word;

    cur_mode  = b64nc_pkg::MODE_ENCODE;
    cur_limit = b64nc_pkg::LIMIT_RESET;
    clear_stream_state();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Encoding with the reset settings: a whole group of the extreme byte
    // values, then a one-byte and a two-byte stream that each end in a tail
    // character and no padding.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hA5, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b1);
    wait_drained();

    // Decoding: a newline at a group start is skipped, the alternative
    // characters for 62 and 63 are taken, and a pad in the third place
    // stops the stream so that the character after it is ignored.
    write_reg(b64nc_pkg::CFG_MODE, CFG_W'(b64nc_pkg::MODE_DECODE));
    queue_byte(b64nc_pkg::CHAR_NEWLINE, 1'b0);
    queue_byte(b64nc_pkg::CHAR_MINUS, 1'b0);
    queue_byte(b64nc_pkg::CHAR_SLASH, 1'b0);
    queue_byte(b64nc_pkg::CHAR_UNDER, 1'b0);
    queue_byte("9", 1'b0);
    queue_byte("Q", 1'b0);
    queue_byte(b64nc_pkg::CHAR_PAD, 1'b0);
    queue_byte(b64nc_pkg::CHAR_PAD, 1'b0);
    queue_byte("A", 1'b1);
    // A newline inside a group is a bad character; the rest is swallowed.
    queue_byte("Q", 1'b0);
    queue_byte(b64nc_pkg::CHAR_NEWLINE, 1'b0);
    queue_byte("A", 1'b1);
    // A stream that ends two characters into a group, and one whose fourth
    // character is a pad.
    queue_byte("Q", 1'b0);
    queue_byte("U", 1'b1);
    queue_byte("Q", 1'b0);
    queue_byte("U", 1'b0);
    queue_byte("0", 1'b0);
    queue_byte(b64nc_pkg::CHAR_PAD, 1'b1);
    // A character outside every alphabet, alone on the final request.
    queue_byte(8'hFF, 1'b1);
    // Half a group, then the mode flips under it: the encoder picks up the
    // held bits and group position the decoder left behind.
    queue_byte("Z", 1'b0);
    queue_byte("z", 1'b0);
    wait_drained();
    write_reg(b64nc_pkg::CFG_MODE, CFG_W'(b64nc_pkg::MODE_ENCODE));
    queue_byte(8'h5A, 1'b1);
    wait_drained();

    // No room at all: the first byte is refused and the stream ends empty.
    write_reg(b64nc_pkg::CFG_OUT_LIMIT, '0);
    queue_byte(8'h11, 1'b1);
    wait_drained();
    // The largest limit the register holds is capped at MAX_OUT.
    write_reg(b64nc_pkg::CFG_OUT_LIMIT, '1);

    // Random part, in three stretches of idling: the sender mostly busy and
    // the receiver mostly stalling, then the reverse, then no idling at all.
    // Each round picks fresh settings and runs a few streams; now and then a
    // round's last stream is left open so the next settings meet it halfway.
    random_start = queued_count;
    while (queued_count - random_start < RANDOM_ITEMS) begin
      wait_drained();
      if (queued_count - random_start >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (queued_count - random_start >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 28;
      end
      mode_word    = CFG_W'($urandom_range(0, 8191));
      write_reg(b64nc_pkg::CFG_MODE, mode_word);
      write_reg(b64nc_pkg::CFG_OUT_LIMIT, pick_limit());
      for (int s = 0; s < 3; s++) begin
        open_end = (s == 2) && ($urandom_range(0, 4) == 0);
        if (cur_mode == b64nc_pkg::MODE_DECODE) queue_text_stream(!open_end);
        else queue_raw_stream(!open_end);
      end
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Far beyond the slowest correct run, even with every stall at its longest.
  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: sim.f
rtl/b64nc_pkg.sv
rtl/b64nc_front.sv
rtl/b64nc_queue.sv
rtl/b64nc_back.sv
rtl/base64_name_codec.sv
bench/base64_name_codec_tb.sv
